[design/bgsb_pkg.sv]
package bgsb_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int CAP_BITS    = STORE_BYTES * 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(CAP_BITS + 1);
  localparam int WIN_W       = 72;

  typedef enum logic [1:0] {
    MODE_WR_BITS = 2'd0,
    MODE_WR_BYTE = 2'd1,
    MODE_RD_BITS = 2'd2,
    MODE_RD_BYTE = 2'd3
  } bgsb_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } bgsb_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_RDLAST,
    S_FINISH
  } bgsb_state_t;

endpackage

[design/bgsb_ram.sv]
module bgsb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/bit_granular_stream_buffer.sv]
// bit granular stream buffer, msb first
// input channel (in_valid / in_stall) carries one operation per beat: in_mode selects
// write bits, aligned write byte, read bits or aligned read byte; in_value holds the
// data to append and in_bit_count the width (above 64 counts as 64, ignored in byte
// modes). every beat gives exactly one result beat on out_valid / out_stall with
// out_read_value (right aligned, zero for writes and flagged operations) and
// out_status (ok, overflow, underflow). a flagged operation changes nothing.
// the store is a byte wide ram with one write and one registered read port,
// walked one byte per cycle; an operation touches 1 to 9 bytes. a write runs through
// S_WRITE, a read through S_READ and S_RDLAST, and zero count and flagged operations
// go straight to S_FINISH, which loads the result once the output register is free.
// the next operation is accepted while a finished result still waits in the
// output register; a result held by out_stall only blocks the one behind it.
// reset clears the write and read positions and the handshake state; the store
// contents are left alone and no clearing pass is run, since reads never pass the
// write position.
module bit_granular_stream_buffer import bgsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_value,
  input  logic [6:0]  in_bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_value,
  output logic [1:0]  out_status
);

  bgsb_state_t        state_r, state_nxt;
  logic [POS_W-1:0]   wp_r, wp_nxt;
  logic [POS_W-1:0]   rp_r, rp_nxt;
  logic [7:0]         tail_r, tail_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [WIN_W-1:0]   acc_r, acc_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [3:0]         nbytes_r, nbytes_nxt;
  logic [2:0]         sh_r, sh_nxt;
  logic [6:0]         n_r, n_nxt;
  logic               is_rd_r, is_rd_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  bgsb_status_t       res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_value_r, out_value_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  bgsb_mode_t         mode;
  logic [6:0]         n_sat, wn, rn;
  logic [2:0]         w_pad, w_off, r_off;
  logic [63:0]        wval, v_al;
  logic [POS_W:0]     w_end, r_end;
  logic [POS_W:0]     r_align;
  logic [POS_W-1:0]   rstart;
  logic               ovf, udf;
  logic [7:0]         w_sum, r_sum;
  logic [WIN_W-1:0]   win_new;
  logic [WIN_W-1:0]   acc_sh;
  logic [63:0]        rd_mask;
  logic               out_free;

  bgsb_ram #(
    .DEPTH(STORE_BYTES),
    .WIDTH(8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operand setup for the accept cycle
  always_comb begin
    mode    = bgsb_mode_t'(in_mode);
    n_sat   = in_bit_count[6] ? 7'd64 : in_bit_count;
    w_off   = wp_r[2:0];
    w_pad   = 3'(4'd8 - {1'b0, w_off});
    wn      = (mode == MODE_WR_BYTE) ? 7'({4'b0, w_pad} + 7'd8) : n_sat;
    wval    = (mode == MODE_WR_BYTE) ? {56'b0, in_value[7:0]} : in_value;
    v_al    = wval << (7'd64 - wn);
    w_end   = {1'b0, wp_r} + (POS_W+1)'(wn);
    ovf     = w_end > (POS_W+1)'(CAP_BITS);
    w_sum   = 8'({5'b0, w_off}) + 8'(wn) + 8'd7;
    win_new = {tail_r & ~(8'hFF >> w_off), 64'b0} | ({v_al, 8'b0} >> w_off);

    r_align = ({1'b0, rp_r} + (POS_W+1)'(7)) & ~(POS_W+1)'(7);
    rstart  = (mode == MODE_RD_BYTE) ? r_align[POS_W-1:0] : rp_r;
    rn      = (mode == MODE_RD_BYTE) ? 7'd8 : n_sat;
    r_off   = rstart[2:0];
    r_end   = {1'b0, rstart} + (POS_W+1)'(rn);
    udf     = r_end > {1'b0, wp_r};
    r_sum   = 8'({5'b0, r_off}) + 8'(rn) + 8'd7;
  end

  // result extraction
  always_comb begin
    acc_sh  = acc_r >> sh_r;
    rd_mask = (n_r == 7'd64) ? '1 : ((64'd1 << n_r[5:0]) - 64'd1);
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    tail_nxt       = tail_r;
    win_nxt        = win_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    nbytes_nxt     = nbytes_r;
    sh_nxt         = sh_r;
    n_nxt          = n_r;
    is_rd_nxt      = is_rd_r;
    res_status_nxt = res_status_r;
    rd_vld_nxt     = (state_r == S_READ);
    acc_nxt        = rd_vld_r ? {acc_r[WIN_W-9:0], ram_rdata} : acc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = base_r + ADDR_W'(cnt_r);
    ram_raddr      = base_r + ADDR_W'(cnt_r);
    ram_wdata      = win_r[WIN_W-1 -: 8];
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_rd_nxt      = 1'b0;
          res_status_nxt = ST_OK;
          cnt_nxt        = 4'd0;
          state_nxt      = S_FINISH;
          if (mode == MODE_WR_BITS || mode == MODE_WR_BYTE) begin
            if (wn == 7'd0) begin
              res_status_nxt = ST_OK;
            end else if (ovf) begin
              res_status_nxt = ST_OVERFLOW;
            end else begin
              win_nxt    = win_new;
              base_nxt   = ADDR_W'(wp_r >> 3);
              nbytes_nxt = w_sum[6:3];
              wp_nxt     = w_end[POS_W-1:0];
              state_nxt  = S_WRITE;
            end
          end else begin
            if (rn == 7'd0) begin
              res_status_nxt = ST_OK;
            end else if (udf) begin
              res_status_nxt = ST_UNDERFLOW;
            end else begin
              base_nxt   = ADDR_W'(rstart >> 3);
              nbytes_nxt = r_sum[6:3];
              sh_nxt     = 3'(~(r_sum[2:0] - 3'd7) + 3'd1);
              n_nxt      = rn;
              rp_nxt     = r_end[POS_W-1:0];
              is_rd_nxt  = 1'b1;
              state_nxt  = S_READ;
            end
          end
        end
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        tail_nxt = win_r[WIN_W-1 -: 8];
        win_nxt  = win_r << 8;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == nbytes_r - 4'd1) begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == nbytes_r - 4'd1) begin
          state_nxt = S_RDLAST;
        end
      end
      S_RDLAST: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = is_rd_r ? (acc_sh[63:0] & rd_mask) : 64'b0;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r       <= tail_nxt;
    win_r        <= win_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    cnt_r        <= cnt_nxt;
    nbytes_r     <= nbytes_nxt;
    sh_r         <= sh_nxt;
    n_r          <= n_nxt;
    is_rd_r      <= is_rd_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

[design/bgsb_checker.sv]
module bgsb_checker import bgsb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_read_value,
  input logic [1:0]  out_status
);

  // reset empties the output side
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_status))
    else $error("stalled result beat changed");

  // flagged operations return no data
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == 64'b0)
    else $error("flagged result carries data");

  // one operation in flight: accept closes the input side
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

endmodule

bind bit_granular_stream_buffer bgsb_checker u_bgsb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_status     (out_status)
);
